// ===== rtl/fmp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the Fibonacci matrix power block: control word types and the microcode table.
// It has no dependencies. The top level and the checker both import it.
package fmp_pkg;

	localparam int UPC_W = 2;

	typedef enum logic [1:0] {
		MUL_FF,
		MUL_GG,
		MUL_FX,
		MUL_NONE
	} mul_sel_t;

	typedef enum logic [1:0] {
		T_HOLD,
		T_LOAD,
		T_ADD,
		T_KEEP
	} t_op_t;

	typedef enum logic {
		JMP_SEQ,
		JMP_BIT
	} jump_t;

	typedef struct packed {
		mul_sel_t   mul_sel;
		t_op_t      t_op;
		logic       commit;
		jump_t      jump;
		logic [UPC_W-1:0] next_upc;
	} ucw_t;

	localparam logic [UPC_W-1:0] UPC_START = '0;

	// One pass of the program handles one exponent bit: a doubling step, then an
	// optional advance step folded into the commit word.
	function automatic ucw_t ucode_word(input logic [UPC_W-1:0] upc);
		ucw_t w;
		unique case (upc)
			2'd0: w = '{mul_sel: MUL_FF, t_op: T_HOLD, commit: 1'b0, jump: JMP_SEQ,
				next_upc: 2'd1};
			2'd1: w = '{mul_sel: MUL_GG, t_op: T_LOAD, commit: 1'b0, jump: JMP_SEQ,
				next_upc: 2'd2};
			2'd2: w = '{mul_sel: MUL_FX, t_op: T_ADD, commit: 1'b0, jump: JMP_SEQ,
				next_upc: 2'd3};
			default: w = '{mul_sel: MUL_NONE, t_op: T_HOLD, commit: 1'b1, jump: JMP_BIT,
				next_upc: UPC_START};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/fibonacci_matrix_power.sv =====
`timescale 1ns / 1ps
// Top level of the Fibonacci matrix power block: microcode sequencer and its datapath.
// It depends on fmp_pkg for the control word types and the microcode table.
//
// The block takes an index n on the s_axis channel and returns F(n), reduced modulo
// 2^RESULT_BITS, on the m_axis channel, with F(0) = 0 and F(1) = 1.
// One item is worked on at a time: s_axis_tready is high whenever no item is in work.
// The accepting edge loads the exponent n-1. A four-step program then runs once for
// every one of the INDEX_BITS exponent bits, from the top bit down, and the result is
// shown once the pass for the lowest bit ends.
// The run time is set by the single shared multiplier, which the doubling step uses
// three times per bit, and by the fixed scan over all exponent bits.
// With a receiver that keeps up, a new item is accepted only once the last one's program ends.
// The result waits in an output register until taken. A new item may be accepted while
// it waits; if it is still not taken when the next result is ready, the program holds
// on its last step until m_axis_tready is high.
// Reset clears the sequencer and the output valid; an item in work or a result not yet taken is dropped.
module fibonacci_matrix_power
	import fmp_pkg::*;
#(
	parameter int INDEX_BITS  = 31,
	parameter int RESULT_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// Bits from the lowest up: index, then zero padding.
	input  logic [((INDEX_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// Bits from the lowest up: fib_value, then zero padding.
	output logic [((RESULT_BITS+7)/8)*8-1:0] m_axis_tdata
);

	localparam int CNT_W  = $clog2(INDEX_BITS);
	localparam int IN_W   = ((INDEX_BITS+7)/8)*8;
	localparam int OUT_W  = ((RESULT_BITS+7)/8)*8;

	logic                   busy_q;
	logic [UPC_W-1:0]       upc_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [INDEX_BITS-1:0]  exp_q;
	logic                   zero_q;
	logic [RESULT_BITS-1:0] f_q;
	logic [RESULT_BITS-1:0] g_q;
	logic [RESULT_BITS-1:0] t_q;
	logic [RESULT_BITS-1:0] prod_q;
	logic                   out_valid_q;
	logic [RESULT_BITS-1:0] out_data_q;

	ucw_t                   ucw;
	logic [RESULT_BITS-1:0] mul_a;
	logic [RESULT_BITS-1:0] mul_b;
	logic [RESULT_BITS-1:0] mul_p;
	logic [RESULT_BITS-1:0] twice_g_minus_f;
	logic [RESULT_BITS-1:0] f_next;
	logic [RESULT_BITS-1:0] g_next;
	logic [INDEX_BITS-1:0]  index_in;
	logic                   in_accept;
	logic                   last_step;
	logic                   stall;
	logic                   step_en;

	assign ucw       = ucode_word(upc_q);
	assign index_in  = s_axis_tdata[INDEX_BITS-1:0];
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign last_step = (ucw.jump == JMP_BIT) && (cnt_q == '0);
	assign stall     = last_step && out_valid_q && !m_axis_tready;
	assign step_en   = busy_q && !stall;

	assign twice_g_minus_f = {g_q[RESULT_BITS-2:0], 1'b0} - f_q;

	always_comb begin
		unique case (ucw.mul_sel)
			MUL_FF: begin
				mul_a = f_q;
				mul_b = f_q;
			end
			MUL_GG: begin
				mul_a = g_q;
				mul_b = g_q;
			end
			MUL_FX: begin
				mul_a = f_q;
				mul_b = twice_g_minus_f;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = RESULT_BITS'(mul_a * mul_b);

	always_comb begin
		if (exp_q[INDEX_BITS-1]) begin
			f_next = t_q;
			g_next = prod_q + t_q;
		end else begin
			f_next = prod_q;
			g_next = t_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			upc_q       <= UPC_START;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (in_accept) begin
				busy_q <= 1'b1;
				upc_q  <= UPC_START;
				cnt_q  <= CNT_W'(INDEX_BITS - 1);
			end else if (step_en) begin
				if (ucw.jump == JMP_BIT) begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						busy_q      <= 1'b0;
						out_valid_q <= 1'b1;
					end
				end
				upc_q <= ucw.next_upc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			exp_q  <= index_in - 1'b1;
			zero_q <= (index_in == '0);
			f_q    <= '0;
			g_q    <= RESULT_BITS'(1);
		end else if (step_en) begin
			if (ucw.mul_sel != MUL_NONE) begin
				prod_q <= mul_p;
			end
			unique case (ucw.t_op)
				T_LOAD:  t_q <= prod_q;
				T_ADD:   t_q <= t_q + prod_q;
				default: t_q <= t_q;
			endcase
			if (ucw.commit) begin
				f_q   <= f_next;
				g_q   <= g_next;
				exp_q <= {exp_q[INDEX_BITS-2:0], 1'b0};
			end
			if (last_step) begin
				out_data_q <= zero_q ? '0 : g_next;
			end
		end
	end

	assign s_axis_tready = !busy_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);

	logic unused_pad;
	assign unused_pad = ^{1'b0, s_axis_tdata[IN_W-1:0]} & 1'b0;

endmodule

// ===== rtl/fmp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the Fibonacci matrix power block, bound to its top level.
// It depends on fmp_pkg and sees only the ports of fibonacci_matrix_power.
module fmp_checker
	import fmp_pkg::*;
#(
	parameter int INDEX_BITS  = 31,
	parameter int RESULT_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [((INDEX_BITS+7)/8)*8-1:0] s_axis_tdata,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [((RESULT_BITS+7)/8)*8-1:0] m_axis_tdata
);

	localparam logic [UPC_W-1:0] START_CHECK = UPC_START;

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready && (START_CHECK == '0);

	// A result that is waiting must stay put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Output item changed or dropped while stalled.");

	// Only one item is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("Input accepted while an item is in work.");

	// A result is shown only at the end of the program, so no new result appears right after an accept.
	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(m_axis_tvalid))
		else $error("Result appeared one cycle after an accept.");

	// A fresh result means the work is done and the input side is free again.
	a_free_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("Result shown while the input side is still busy.");

endmodule

bind fibonacci_matrix_power fmp_checker #(
	.INDEX_BITS(INDEX_BITS),
	.RESULT_BITS(RESULT_BITS)
) u_fmp_checker (.*);
